@@ src/w256_pkg.sv @@
// package for the 256-bit word alu: operation codes, sequencer states, widths
// no dependencies
`timescale 1ns / 1ps
package w256_pkg;
  localparam int unsigned WordW = 256;
  localparam int unsigned LimbW = 64;
  localparam int unsigned FuncW = 5;
  localparam int unsigned CntW  = 8;
  localparam int unsigned MulW  = 32;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_GT = 5'd8, OP_EQ = 5'd9,
    OP_LT = 5'd10, OP_EXP = 5'd11, OP_SMOD = 5'd12, OP_SDIV = 5'd13,
    OP_SGT = 5'd14, OP_SLT = 5'd15, OP_SHL = 5'd16, OP_SHR = 5'd17,
    OP_SAR = 5'd18, OP_NOT = 5'd19
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_SQR, ST_SHIFT, ST_DONE
  } state_t;
endpackage

@@ src/word256_alu_top.sv @@
// top level of the 256-bit word alu: iterative sequencer around one shared
// 256-bit adder, a 32x32 multiplier and a one-bit shifter; uses w256_pkg
`timescale 1ns / 1ps
// channel | dir | tdata fields (lsb first)
// in_     | in  | func[4:0], a_w0..a_w3, b_w0..b_w3 (517 bits, 11 pad -> 528)
// out_    | out | r_w0..r_w3 (256 bits)
// work: logic ops, compares, add/sub done on acceptance; shifts one step per amount bit;
// div/mod one restoring bit step a cycle, none for a zero divisor; mul 36 partial
// products of 32x32 through one multiplier; exp a mul and a square per exponent bit.
// reset: rst_n synchronous low clears the sequencer and output valid.
// stalls: in_tready is low while an item is in work or its result is unread.
module word256_alu_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [527:0]                in_tdata,   // func, a_w0..a_w3, b_w0..b_w3, pad
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [w256_pkg::WordW-1:0]  out_tdata   // r_w0, r_w1, r_w2, r_w3
);
  localparam int unsigned WIDTH = w256_pkg::WordW;
  localparam int unsigned NL = WIDTH / w256_pkg::MulW;
  localparam int unsigned LW = $clog2(NL);

  w256_pkg::state_t state_r, state_nxt;
  logic [4:0]        func_r;
  logic [WIDTH-1:0]  a_r, b_r, acc_r, rem_r, quo_r, base_r, res_r;
  logic [w256_pkg::CntW:0] cnt_r;
  logic [LW-1:0]     mi_r, mj_r;
  logic              neg_q_r, neg_r_r, exp_mode_r, out_valid_r;
  logic [WIDTH-1:0]  mul_x_r, mul_y_r, prod_r;

  logic [4:0]       in_func;
  logic [WIDTH-1:0] in_a, in_b;
  assign in_func = in_tdata[4:0];
  assign in_a    = in_tdata[5 +: WIDTH];
  assign in_b    = in_tdata[5+WIDTH +: WIDTH];

  // shared adder
  logic [WIDTH-1:0] add_x, add_y, add_s;
  logic             add_cin;
  assign add_s = add_x + add_y + WIDTH'(add_cin);

  // shared multiplier: one 32x32 partial product per cycle
  logic [w256_pkg::MulW-1:0] mx, my;
  logic [2*w256_pkg::MulW-1:0] pp;
  assign mx = mul_x_r[mi_r*w256_pkg::MulW +: w256_pkg::MulW];
  assign my = mul_y_r[mj_r*w256_pkg::MulW +: w256_pkg::MulW];
  assign pp = mx * my;
  logic [WIDTH-1:0] pp_sh;
  assign pp_sh = {{(WIDTH-2*w256_pkg::MulW){1'b0}}, pp}
                 << ((mi_r + mj_r) * w256_pkg::MulW);

  logic a_neg, b_neg, big;
  assign a_neg = in_a[WIDTH-1];
  assign b_neg = in_b[WIDTH-1];
  assign big   = (in_a[WIDTH-1:8] != '0);

  logic [WIDTH:0] rem_sh;
  assign rem_sh = {rem_r, a_r[WIDTH-1]};
  logic div_ge;
  assign div_ge = rem_sh >= {1'b0, b_r};

  always_comb begin
    add_x = rem_sh[WIDTH-1:0];
    add_y = ~b_r;
    add_cin = 1'b1;
    if (state_r == w256_pkg::ST_IDLE) begin
      add_x = in_a;
      add_y = (in_func == w256_pkg::OP_ADD) ? in_b : ~in_b;
      add_cin = (in_func != w256_pkg::OP_ADD);
    end else if (state_r == w256_pkg::ST_MUL || state_r == w256_pkg::ST_SQR) begin
      add_x = prod_r;
      add_y = pp_sh;
      add_cin = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      w256_pkg::ST_IDLE: if (in_tvalid && in_tready) begin
        case (in_func)
          w256_pkg::OP_DIV, w256_pkg::OP_MOD, w256_pkg::OP_SDIV, w256_pkg::OP_SMOD:
            state_nxt = (in_b == '0) ? w256_pkg::ST_DONE : w256_pkg::ST_DIV;
          w256_pkg::OP_MUL: state_nxt = w256_pkg::ST_MUL;
          w256_pkg::OP_EXP: state_nxt = w256_pkg::ST_MUL;
          w256_pkg::OP_SHL, w256_pkg::OP_SHR, w256_pkg::OP_SAR:
            state_nxt = (big || in_a[7:0] == '0) ? w256_pkg::ST_DONE : w256_pkg::ST_SHIFT;
          default: state_nxt = w256_pkg::ST_DONE;
        endcase
      end
      w256_pkg::ST_DIV: if (cnt_r == 9'd255) state_nxt = w256_pkg::ST_DONE;
      w256_pkg::ST_MUL: if (mi_r == LW'(NL-1) && mj_r == '0)
        state_nxt = exp_mode_r ? w256_pkg::ST_SQR : w256_pkg::ST_DONE;
      w256_pkg::ST_SQR: if (mi_r == LW'(NL-1) && mj_r == '0)
        state_nxt = (cnt_r == 9'd255) ? w256_pkg::ST_DONE : w256_pkg::ST_MUL;
      w256_pkg::ST_SHIFT: if (cnt_r == 9'd1) state_nxt = w256_pkg::ST_DONE;
      w256_pkg::ST_DONE: if (!out_valid_r || out_tready) state_nxt = w256_pkg::ST_IDLE;
      default: state_nxt = w256_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = (state_r == w256_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  end

  logic mul_last;
  assign mul_last = (mi_r == LW'(NL-1)) && (mj_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= w256_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == w256_pkg::ST_DONE) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      w256_pkg::ST_IDLE: begin
        func_r <= in_func;
        a_r <= in_a;
        b_r <= in_b;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
        mi_r <= '0;
        mj_r <= LW'(NL-1);
        prod_r <= '0;
        exp_mode_r <= (in_func == w256_pkg::OP_EXP);
        neg_q_r <= a_neg ^ b_neg;
        neg_r_r <= a_neg;
        mul_x_r <= in_a;
        mul_y_r <= in_b;
        acc_r <= '0;
        base_r <= in_a;
        case (in_func)
          w256_pkg::OP_ADD, w256_pkg::OP_SUB: acc_r <= add_s;
          w256_pkg::OP_AND: acc_r <= in_a & in_b;
          w256_pkg::OP_OR:  acc_r <= in_a | in_b;
          w256_pkg::OP_XOR: acc_r <= in_a ^ in_b;
          w256_pkg::OP_NOT: acc_r <= ~in_a;
          w256_pkg::OP_GT:  acc_r <= WIDTH'(in_a > in_b);
          w256_pkg::OP_LT:  acc_r <= WIDTH'(in_a < in_b);
          w256_pkg::OP_EQ:  acc_r <= WIDTH'(in_a == in_b);
          w256_pkg::OP_SGT: acc_r <= WIDTH'($signed(in_a) > $signed(in_b));
          w256_pkg::OP_SLT: acc_r <= WIDTH'($signed(in_a) < $signed(in_b));
          w256_pkg::OP_SDIV, w256_pkg::OP_SMOD: begin
            a_r <= a_neg ? (~in_a + 1'b1) : in_a;
            b_r <= b_neg ? (~in_b + 1'b1) : in_b;
          end
          w256_pkg::OP_EXP: begin
            acc_r <= WIDTH'(1);
            mul_x_r <= WIDTH'(1);
            mul_y_r <= in_a;
          end
          w256_pkg::OP_SHL, w256_pkg::OP_SHR, w256_pkg::OP_SAR: begin
            cnt_r <= {1'b0, in_a[7:0]};
            acc_r <= big ? ((in_func == w256_pkg::OP_SAR && b_neg) ? '1 : '0) : in_b;
          end
          default: ;
        endcase
      end
      w256_pkg::ST_DIV: begin
        rem_r <= div_ge ? add_s : rem_sh[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], div_ge};
        a_r <= {a_r[WIDTH-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      w256_pkg::ST_MUL, w256_pkg::ST_SQR: begin
        // only partial products landing below 2^256 are taken
        if ((32'(mi_r) + 32'(mj_r)) < NL) prod_r <= add_s;
        if (mj_r == '0) begin
          mj_r <= LW'(NL-1) - mi_r - 1'b1;
          mi_r <= mi_r + 1'b1;
        end else mj_r <= mj_r - 1'b1;
        if (mul_last) begin
          mi_r <= '0;
          mj_r <= LW'(NL-1);
          prod_r <= '0;
          if (!exp_mode_r) acc_r <= add_s;
          else if (state_r == w256_pkg::ST_MUL) begin
            // product of acc and base; keep it only if exponent bit set
            if (b_r[0]) acc_r <= add_s;
            mul_x_r <= base_r;
            mul_y_r <= base_r;
          end else begin
            base_r <= add_s;
            b_r <= {1'b0, b_r[WIDTH-1:1]};
            cnt_r <= cnt_r + 1'b1;
            mul_x_r <= acc_r;
            mul_y_r <= add_s;
          end
        end
      end
      w256_pkg::ST_SHIFT: begin
        cnt_r <= cnt_r - 1'b1;
        case (func_r)
          w256_pkg::OP_SHL: acc_r <= {acc_r[WIDTH-2:0], 1'b0};
          w256_pkg::OP_SHR: acc_r <= {1'b0, acc_r[WIDTH-1:1]};
          default:          acc_r <= {acc_r[WIDTH-1], acc_r[WIDTH-1:1]};
        endcase
      end
      w256_pkg::ST_DONE: if (!out_valid_r || out_tready) begin
        case (func_r)
          w256_pkg::OP_DIV: res_r <= (b_r == '0) ? '0 : quo_r;
          w256_pkg::OP_MOD: res_r <= (b_r == '0) ? '0 : rem_r;
          w256_pkg::OP_SDIV: res_r <= (b_r == '0) ? '0 : (neg_q_r ? ~quo_r + 1'b1 : quo_r);
          w256_pkg::OP_SMOD: res_r <= (b_r == '0) ? '0 : (neg_r_r ? ~rem_r + 1'b1 : rem_r);
          default: res_r <= (func_r > w256_pkg::OP_NOT) ? '0 : acc_r;
        endcase
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  // mi/mj walk the lower triangle each multiply, every row from mj = NL-1-mi down to 0

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != w256_pkg::ST_IDLE) |-> !in_tready)
    else $error("input accepted while busy");
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped under stall");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == w256_pkg::ST_DIV) |-> (cnt_r <= 9'd255))
    else $error("division step count overrun");
endmodule

@@ verif/word256_alu_checker.sv @@
// checker for word256_alu_top: watches both stream channels, predicts each
// 256-bit result from the accepted operands and compares word by word; uses w256_pkg
`timescale 1ns / 1ps
module word256_alu_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [527:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [255:0] out_tdata,
  output int           errors,
  output int           pending
);
  logic [255:0] expected_words[$];

  function automatic logic [255:0] alu_result(logic [4:0] f, logic [255:0] a,
                                              logic [255:0] b);
    logic [255:0] r, ma, mb, q, m, base;
    logic         big;
    logic [7:0]   amt;
    r    = '0;
    big  = (a >= 256);
    amt  = a[7:0];
    ma   = a[255] ? -a : a;
    mb   = b[255] ? -b : b;
    case (f)
      w256_pkg::OP_ADD: r = a + b;
      w256_pkg::OP_SUB: r = a - b;
      w256_pkg::OP_MUL: r = a * b;
      w256_pkg::OP_DIV: if (b != 0) r = a / b;
      w256_pkg::OP_MOD: if (b != 0) r = a % b;
      w256_pkg::OP_AND: r = a & b;
      w256_pkg::OP_OR:  r = a | b;
      w256_pkg::OP_XOR: r = a ^ b;
      w256_pkg::OP_GT:  r = 256'(a > b);
      w256_pkg::OP_EQ:  r = 256'(a == b);
      w256_pkg::OP_LT:  r = 256'(a < b);
      w256_pkg::OP_EXP: begin
        r    = 1;
        base = a;
        for (int i = 0; i < 256; i++) begin
          if (b[i]) r = r * base;
          base = base * base;
        end
      end
      w256_pkg::OP_SMOD: if (b != 0) begin
        m = ma % mb;
        r = a[255] ? -m : m;
      end
      w256_pkg::OP_SDIV: if (b != 0) begin
        q = ma / mb;
        r = (a[255] != b[255]) ? -q : q;
      end
      w256_pkg::OP_SGT: r = 256'($signed(a) > $signed(b));
      w256_pkg::OP_SLT: r = 256'($signed(a) < $signed(b));
      w256_pkg::OP_SHL: if (!big) r = b << amt;
      w256_pkg::OP_SHR: if (!big) r = b >> amt;
      w256_pkg::OP_SAR: r = big ? {256{b[255]}} : 256'($signed(b) >>> amt);
      w256_pkg::OP_NOT: r = ~a;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    logic [255:0] want;
    int           bad;
    bad = 0;
    if (!rst_n) begin
      expected_words.delete();
      errors <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_words.push_back(alu_result(in_tdata[4:0], in_tdata[260:5],
                                            in_tdata[516:261]));
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("result transaction with nothing expected: %h", out_tdata);
          bad++;
        end else begin
          want = expected_words.pop_front();
          for (int w = 0; w < 4; w++)
            if (out_tdata[w*64 +: 64] !== want[w*64 +: 64]) begin
              $error("r_w%0d expected %h actual %h", w, want[w*64 +: 64],
                     out_tdata[w*64 +: 64]);
              bad++;
            end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end
endmodule

@@ verif/tb_word256_alu_top.sv @@
// testbench top for word256_alu_top: drives operand transactions with random
// gaps and result back-pressure; checking lives in word256_alu_checker
`timescale 1ns / 1ps
module tb_word256_alu_top;
  localparam int IdleLimit = 200000;
  localparam logic [255:0] AllOnes = '1;
  localparam logic [255:0] MinNeg  = 256'b1 << 255;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [527:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [255:0] out_tdata;
  int           errors, pending;
  int           sent = 0;
  int           idle_cycles = 0;
  int           exp_budget = 8;

  always #1 clk = ~clk;

  word256_alu_top dut (.*);

  word256_alu_checker checker_i (.*);

  function automatic logic [255:0] pick_operand();
    logic [255:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 1;
      2: v = AllOnes;
      3: v = MinNeg;
      4: v = ~MinNeg;
      5: v = $urandom_range(0, 1000);
      6: v = -256'($urandom_range(1, 1000));
      7: v = v >> $urandom_range(0, 255);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [255:0] pick_amount();
    case ($urandom_range(0, 7))
      0: return pick_operand();
      1: return $urandom_range(250, 300);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic send_op(logic [4:0] f, logic [255:0] a, logic [255:0] b);
    int gap;
    in_tvalid <= 1;
    in_tdata  <= {11'b0, b, a, f};
    do @(posedge clk); while (!in_tready);
    sent++;
    gap = ($urandom_range(0, 3) == 0) ? 0 :
          ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random stalls, one long hold-off while the sender keeps offering operands
  initial begin
    int stall;
    bit held;
    held = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held && sent >= 300) begin
        held = 1;
        out_tready <= 0;
        repeat (500) @(posedge clk);
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 :
              ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
      if (stall > 0 && sent > 40 && sent < 1400) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [4:0]   f;
    logic [255:0] a, b;
    int           waited;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_op(w256_pkg::OP_ADD, AllOnes, AllOnes);
    send_op(w256_pkg::OP_SUB, 0, 1);
    send_op(w256_pkg::OP_MUL, AllOnes, AllOnes);
    send_op(w256_pkg::OP_DIV, pick_operand(), 0);
    send_op(w256_pkg::OP_MOD, AllOnes, 0);
    send_op(w256_pkg::OP_DIV, AllOnes, 3);
    send_op(w256_pkg::OP_MOD, AllOnes, 1000);
    send_op(w256_pkg::OP_SDIV, MinNeg, AllOnes);
    send_op(w256_pkg::OP_SMOD, -256'd7, 3);
    send_op(w256_pkg::OP_SMOD, 7, -256'd3);
    send_op(w256_pkg::OP_AND, AllOnes, MinNeg);
    send_op(w256_pkg::OP_OR, 0, AllOnes);
    send_op(w256_pkg::OP_XOR, AllOnes, MinNeg);
    send_op(w256_pkg::OP_GT, AllOnes, 0);
    send_op(w256_pkg::OP_EQ, AllOnes, AllOnes);
    send_op(w256_pkg::OP_LT, 0, AllOnes);
    send_op(w256_pkg::OP_SGT, AllOnes, 0);
    send_op(w256_pkg::OP_SLT, MinNeg, ~MinNeg);
    send_op(w256_pkg::OP_SHL, 255, AllOnes);
    send_op(w256_pkg::OP_SHR, 256, AllOnes);
    send_op(w256_pkg::OP_SAR, AllOnes, MinNeg);
    send_op(w256_pkg::OP_SAR, 4, MinNeg);
    send_op(w256_pkg::OP_NOT, MinNeg, AllOnes);
    send_op(5'd25, AllOnes, AllOnes);
    send_op(w256_pkg::OP_EXP, 0, 0);
    send_op(w256_pkg::OP_EXP, 3, pick_operand());

    for (int n = 0; n < 1525; n++) begin
      f = 5'($urandom_range(0, 19));
      if ($urandom_range(0, 19) == 0) f = 5'($urandom_range(20, 31));
      // exp walks every exponent bit, keep it rare
      if (f == w256_pkg::OP_EXP) begin
        if (exp_budget > 0 && $urandom_range(0, 9) == 0) exp_budget--;
        else f = w256_pkg::OP_ADD;
      end
      a = pick_operand();
      b = pick_operand();
      if (f == w256_pkg::OP_SHL || f == w256_pkg::OP_SHR || f == w256_pkg::OP_SAR)
        a = pick_amount();
      send_op(f, a, b);
    end
    in_tvalid <= 0;

    waited = 0;
    while (pending != 0 && waited < IdleLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (40000) @(posedge clk);
    if (errors == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
